// ----- rtl/fir_valid_convolution_mac_defines.svh -----
// Assertion macros used by the FIR convolution top level.
`ifndef FIR_VALID_CONVOLUTION_MAC_DEFINES_SVH
`define FIR_VALID_CONVOLUTION_MAC_DEFINES_SVH

// Plain property, checked at every rising clock edge outside reset.
`define FVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Property whose consequent is checked in the cycle after its antecedent.
`define FVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fvc_pkg.sv -----
// Shared constants, codes and types of the FIR convolution block.
package fvc_pkg;

  localparam int DEF_MAX_TAPS    = 64;
  localparam int DEF_MAX_BLOCK   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_ACC_BITS    = 40;

  localparam int TAP_IDX_BITS   = 6;
  localparam int TAP_COUNT_BITS = 7;
  localparam int MODE_BITS      = 2;
  localparam int OUT_IDX_BITS   = 12;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 7;

  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t MODE_REAL        = 2'd0;
  localparam mode_t MODE_CPLX_SAMPLE = 2'd1;
  localparam mode_t MODE_CPLX_TAP    = 2'd2;
  localparam mode_t MODE_RSVD        = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DATA_MODE = 1'd1;

  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                    shift;
    logic                    tap_we;
    logic [TAP_IDX_BITS-1:0] tap_idx;
    mode_t                   mode;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SUM
  } fsm_state_t;

endpackage

// ----- rtl/fvc_in_if.sv -----
// Input channel: tap writes and samples with their prior output values.
interface fvc_in_if import fvc_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int ACC_BITS    = DEF_ACC_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic                          block_start;
  logic [TAP_IDX_BITS-1:0]       tap_index;
  logic signed [SAMPLE_BITS-1:0] tap_re;
  logic signed [SAMPLE_BITS-1:0] tap_im;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;
  logic signed [ACC_BITS-1:0]    acc_re;
  logic signed [ACC_BITS-1:0]    acc_im;

  modport source (
    output valid, req_type, block_start, tap_index, tap_re, tap_im,
           sample_re, sample_im, acc_re, acc_im,
    input  ready
  );

  modport sink (
    input  valid, req_type, block_start, tap_index, tap_re, tap_im,
           sample_re, sample_im, acc_re, acc_im,
    output ready
  );
endinterface

// ----- rtl/fvc_out_if.sv -----
// Result channel: accumulated outputs with index and saturation flag.
interface fvc_out_if import fvc_pkg::*; #(
  parameter int ACC_BITS = DEF_ACC_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic signed [ACC_BITS-1:0] out_re;
  logic signed [ACC_BITS-1:0] out_im;
  logic [OUT_IDX_BITS-1:0]    out_index;
  logic                       saturated;

  modport source (
    output valid, out_re, out_im, out_index, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_re, out_im, out_index, saturated,
    output ready
  );
endinterface

// ----- rtl/fvc_tap_cell.sv -----
// One cell of the FIR chain: a delay tap, its coefficient and a partial-sum stage.
module fvc_tap_cell import fvc_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int PSUM_BITS   = 2 * DEF_SAMPLE_BITS + 6,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk,
  input  cell_ctl_t                     ctl,
  input  logic                          active,
  input  logic signed [SAMPLE_BITS-1:0] x_re_in,
  input  logic signed [SAMPLE_BITS-1:0] x_im_in,
  input  logic signed [SAMPLE_BITS-1:0] tap_re_in,
  input  logic signed [SAMPLE_BITS-1:0] tap_im_in,
  input  logic signed [PSUM_BITS-1:0]   psum_re_in,
  input  logic signed [PSUM_BITS-1:0]   psum_im_in,
  output logic signed [SAMPLE_BITS-1:0] x_re_out,
  output logic signed [SAMPLE_BITS-1:0] x_im_out,
  output logic signed [PSUM_BITS-1:0]   psum_re_out,
  output logic signed [PSUM_BITS-1:0]   psum_im_out
);

  localparam int PROD_BITS = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] x_re_r, x_im_r, t_re_r, t_im_r;
  logic signed [PSUM_BITS-1:0]   psum_re_r, psum_im_r;
  logic signed [PSUM_BITS-1:0]   psum_re_nxt, psum_im_nxt;
  logic signed [SAMPLE_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0]   prod_re, prod_im;
  logic                          im_on, tap_hit;

  assign tap_hit = ctl.tap_we && (int'(ctl.tap_idx) == CELL_IDX);

  // Imaginary lane: sample imag by tap real, or sample real by tap imag.
  always_comb begin
    mul_a   = (ctl.mode == MODE_CPLX_SAMPLE) ? x_im_r : x_re_r;
    mul_b   = (ctl.mode == MODE_CPLX_TAP) ? t_im_r : t_re_r;
    im_on   = (ctl.mode == MODE_CPLX_SAMPLE) || (ctl.mode == MODE_CPLX_TAP);
    prod_re = x_re_r * t_re_r;
    prod_im = mul_a * mul_b;
    psum_re_nxt = psum_re_in;
    psum_im_nxt = psum_im_in;
    if (active) begin
      psum_re_nxt = psum_re_in + {{(PSUM_BITS-PROD_BITS){prod_re[PROD_BITS-1]}}, prod_re};
      if (im_on) begin
        psum_im_nxt = psum_im_in + {{(PSUM_BITS-PROD_BITS){prod_im[PROD_BITS-1]}}, prod_im};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      x_re_r <= x_re_in;
      x_im_r <= x_im_in;
    end
    if (tap_hit) begin
      t_re_r <= tap_re_in;
      t_im_r <= tap_im_in;
    end
    psum_re_r <= psum_re_nxt;
    psum_im_r <= psum_im_nxt;
  end

  assign x_re_out    = x_re_r;
  assign x_im_out    = x_im_r;
  assign psum_re_out = psum_re_r;
  assign psum_im_out = psum_im_r;

endmodule

// ----- rtl/fir_valid_convolution_mac.sv -----
// Top level: FIR convolution over a block, valid region only, accumulating into a prior value.
//
// in_if carries one word per handshake: req_type 0 writes tap tap_index (real and
// imaginary part), req_type 1 delivers a sample with the prior output value
// acc_re/acc_im. block_start on a sample restarts the block's fill count.
// cfg_we/cfg_index/cfg_data write tap_count and data_mode; write them only while
// the block has no result pending.
// Once tap_count samples of a block are in (0 acts as 1, above MAX_TAPS as MAX_TAPS),
// each sample yields one word on out_if: acc plus the dot product of the newest
// samples with the taps, saturated to the accumulator range, with the block position
// of the window's middle sample. Tap writes and fill samples leave the block idle,
// in_if.ready high. A sample that yields a result holds in_if.ready low while the
// partial sum walks the MAX_TAPS-cell chain one cell per cycle and the output
// register then takes acc plus the sum, saturated; only then does in_if take another
// word. A stalled result sits in the output register; a following result waits at
// the end of the chain until it drains. Samples past MAX_BLOCK in a block are
// dropped. Reset sets tap_count to 1, data_mode to real and clears the fill count;
// taps and delay line are undefined until written.
module fir_valid_convolution_mac import fvc_pkg::*; #(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int ACC_BITS    = DEF_ACC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  fvc_in_if.sink                   in_if,
  fvc_out_if.source                out_if,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  `include "fir_valid_convolution_mac_defines.svh"

  localparam int PSUM_BITS = 2 * SAMPLE_BITS + $clog2(MAX_TAPS);
  localparam int TW   = ((ACC_BITS > PSUM_BITS) ? ACC_BITS : PSUM_BITS) + 1;
  localparam int LW   = $clog2(MAX_TAPS + 1);
  localparam int CW   = (TAP_COUNT_BITS > LW) ? TAP_COUNT_BITS : LW;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int EW0  = (CNT_W > OUT_IDX_BITS) ? CNT_W : OUT_IDX_BITS;
  localparam int EW   = ((EW0 > LW) ? EW0 : LW) + 1;
  localparam int SCW  = $clog2(MAX_TAPS + 1);
  localparam logic signed [ACC_BITS-1:0] SAT_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

  // {clip flag, clipped value}
  function automatic logic [ACC_BITS:0] sat_fn(input logic signed [TW-1:0] v);
    logic [TW-ACC_BITS:0] top;
    logic [ACC_BITS:0]    res;
    begin
      top = v[TW-1:ACC_BITS-1];
      if ((&top) || !(|top)) begin
        res = {1'b0, v[ACC_BITS-1:0]};
      end else if (v[TW-1]) begin
        res = {1'b1, SAT_LO};
      end else begin
        res = {1'b1, SAT_HI};
      end
      sat_fn = res;
    end
  endfunction

  // configuration
  logic [TAP_COUNT_BITS-1:0] tap_count_r;
  mode_t                     data_mode_r;
  mode_t                     mode_eff;
  logic [CW-1:0]             tc_w, l_cl;
  logic [LW-1:0]             l_eff, l_half;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_BITS'(1);
      data_mode_r <= MODE_REAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT: tap_count_r <= cfg_data[TAP_COUNT_BITS-1:0];
        REG_DATA_MODE: data_mode_r <= cfg_data[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_eff = (data_mode_r == MODE_RSVD) ? MODE_REAL : data_mode_r;
    tc_w     = CW'(tap_count_r);
    if (tc_w == '0) begin
      l_cl = CW'(1);
    end else if (tc_w > CW'(MAX_TAPS)) begin
      l_cl = CW'(MAX_TAPS);
    end else begin
      l_cl = tc_w;
    end
    l_eff  = LW'(l_cl);
    l_half = (l_eff - LW'(1)) >> 1;
  end

  // input decode and block count
  fsm_state_t       state_r, state_nxt;
  logic             in_fire, is_sample, room, gen, shift, tap_we;
  logic             out_load, out_free;
  logic [CNT_W-1:0] blk_cnt_r, blk_cnt_nxt, blk_base, blk_new;
  logic [EW-1:0]    idx_calc;
  logic [SCW-1:0]   sum_cnt_r;

  assign in_fire   = in_if.valid && in_if.ready;
  assign is_sample = (in_if.req_type == REQ_SAMPLE);

  always_comb begin
    blk_base    = in_if.block_start ? '0 : blk_cnt_r;
    room        = (blk_base < CNT_W'(MAX_BLOCK));
    blk_new     = blk_base + CNT_W'(1);
    gen         = room && (EW'(blk_new) >= EW'(l_eff));
    shift       = in_fire && is_sample && room;
    tap_we      = in_fire && !is_sample;
    blk_cnt_nxt = room ? blk_new : blk_base;
    idx_calc    = EW'(blk_new) - EW'(l_eff) + EW'(l_half);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= '0;
    end else if (in_fire && is_sample) begin
      blk_cnt_r <= blk_cnt_nxt;
    end
  end

  // sequencer
  assign out_free = !out_if.valid || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire && is_sample && gen) state_nxt = ST_SUM;
      ST_SUM:  if ((sum_cnt_r == '0) && out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: in_if.ready = 1'b1;
      ST_SUM:  out_load = (sum_cnt_r == '0) && out_free;
      default: in_if.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sum_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        sum_cnt_r <= SCW'(MAX_TAPS);
      end else if (sum_cnt_r != '0) begin
        sum_cnt_r <= sum_cnt_r - SCW'(1);
      end
    end
  end

  // per-word payload held for the final add
  logic signed [ACC_BITS-1:0] acc_re_r, acc_im_r;
  logic [OUT_IDX_BITS-1:0]    idx_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      acc_re_r <= in_if.acc_re;
      acc_im_r <= in_if.acc_im;
      idx_r    <= idx_calc[OUT_IDX_BITS-1:0];
    end
  end

  // cell chain
  cell_ctl_t ctl;
  logic signed [SAMPLE_BITS-1:0] x_re_w [MAX_TAPS+1];
  logic signed [SAMPLE_BITS-1:0] x_im_w [MAX_TAPS+1];
  logic signed [PSUM_BITS-1:0]   ps_re_w [MAX_TAPS+1];
  logic signed [PSUM_BITS-1:0]   ps_im_w [MAX_TAPS+1];

  assign ctl.shift   = shift;
  assign ctl.tap_we  = tap_we;
  assign ctl.tap_idx = in_if.tap_index;
  assign ctl.mode    = mode_eff;

  assign x_re_w[0]  = in_if.sample_re;
  assign x_im_w[0]  = in_if.sample_im;
  assign ps_re_w[0] = '0;
  assign ps_im_w[0] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    fvc_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PSUM_BITS   (PSUM_BITS),
      .CELL_IDX    (k)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .active      (l_eff > LW'(k)),
      .x_re_in     (x_re_w[k]),
      .x_im_in     (x_im_w[k]),
      .tap_re_in   (in_if.tap_re),
      .tap_im_in   (in_if.tap_im),
      .psum_re_in  (ps_re_w[k]),
      .psum_im_in  (ps_im_w[k]),
      .x_re_out    (x_re_w[k+1]),
      .x_im_out    (x_im_w[k+1]),
      .psum_re_out (ps_re_w[k+1]),
      .psum_im_out (ps_im_w[k+1])
    );
  end

  // final add and saturate
  logic signed [TW-1:0]       sum_re, sum_im;
  logic [ACC_BITS:0]          sat_re, sat_im;
  logic                       out_valid_r, sat_r;
  logic signed [ACC_BITS-1:0] out_re_r, out_im_r;
  logic [OUT_IDX_BITS-1:0]    out_idx_r;

  always_comb begin
    sum_re = {{(TW-PSUM_BITS){ps_re_w[MAX_TAPS][PSUM_BITS-1]}}, ps_re_w[MAX_TAPS]}
           + {{(TW-ACC_BITS){acc_re_r[ACC_BITS-1]}}, acc_re_r};
    sum_im = {{(TW-PSUM_BITS){ps_im_w[MAX_TAPS][PSUM_BITS-1]}}, ps_im_w[MAX_TAPS]}
           + {{(TW-ACC_BITS){acc_im_r[ACC_BITS-1]}}, acc_im_r};
    sat_re = sat_fn(sum_re);
    sat_im = sat_fn(sum_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r  <= sat_re[ACC_BITS-1:0];
      out_idx_r <= idx_r;
      if (mode_eff == MODE_REAL) begin
        out_im_r <= '0;
        sat_r    <= sat_re[ACC_BITS];
      end else begin
        out_im_r <= sat_im[ACC_BITS-1:0];
        sat_r    <= sat_re[ACC_BITS] || sat_im[ACC_BITS];
      end
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_re    = out_re_r;
  assign out_if.out_im    = out_im_r;
  assign out_if.out_index = out_idx_r;
  assign out_if.saturated = sat_r;

  `FVC_ASSERT_NEXT(a_start_loads_count, in_fire && is_sample && gen,
    state_r == ST_SUM && sum_cnt_r == SCW'(MAX_TAPS), "sum wave did not start")
  `FVC_ASSERT(a_out_from_sum, $rose(out_valid_r) |-> $past(state_r == ST_SUM),
    "result word appeared without a sum pass")
  `FVC_ASSERT(a_blk_bound, blk_cnt_r <= CNT_W'(MAX_BLOCK), "block count past limit")
  `FVC_ASSERT(a_sat_at_rail, (out_valid_r && sat_r) |-> (out_re_r == SAT_HI ||
    out_re_r == SAT_LO || out_im_r == SAT_HI || out_im_r == SAT_LO),
    "saturation flag without a clipped value")

endmodule

// ----- tb/sv/tb_fir_valid_convolution_mac.sv -----
// Self-checking testbench for the FIR convolution MAC: directed rows, random and over-range phases.
module tb_fir_valid_convolution_mac import fvc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DEF_SAMPLE_BITS-1:0] q15_t;
  typedef logic signed [DEF_ACC_BITS-1:0]    q30_t;

  typedef struct {
    logic                    req;
    logic                    bstart;
    logic [TAP_IDX_BITS-1:0] tidx;
    q15_t                    tre;
    q15_t                    tim;
    q15_t                    sre;
    q15_t                    sim;
    q30_t                    are;
    q30_t                    aim;
  } fir_word_t;

  typedef struct {
    q30_t                    re;
    q30_t                    im;
    logic [OUT_IDX_BITS-1:0] idx;
    logic                    sat;
  } fir_result_t;

  typedef enum {ROW_WORD, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    fir_word_t                w;
    fir_result_t              want;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
  } stim_row_t;

  localparam q30_t   ACC_MAX        = {1'b0, {(DEF_ACC_BITS-1){1'b1}}};
  localparam q30_t   ACC_MIN        = {1'b1, {(DEF_ACC_BITS-1){1'b0}}};
  localparam longint ACC_HI         = (longint'(1) <<< (DEF_ACC_BITS-1)) - 1;
  localparam longint ACC_LO         = -ACC_HI - 1;
  localparam int     HOLD_OFF       = DEF_MAX_TAPS + 4;
  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     RANDOM_WORDS   = 520;

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  fvc_in_if  in_if ();
  fvc_out_if out_if ();

  fir_valid_convolution_mac DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block: taps, delay line, fill count, registers
  q15_t                      coef_re [DEF_MAX_TAPS];
  q15_t                      coef_im [DEF_MAX_TAPS];
  q15_t                      line_re [DEF_MAX_TAPS];
  q15_t                      line_im [DEF_MAX_TAPS];
  bit                        tap_written [DEF_MAX_TAPS];
  int                        fill;
  logic [TAP_COUNT_BITS-1:0] cfg_taps;
  mode_t                     cfg_mode;

  fir_result_t results_due [$];
  fir_result_t head;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;

  function automatic int effective_len();
    if (cfg_taps == 0) return 1;
    if (cfg_taps > DEF_MAX_TAPS) return DEF_MAX_TAPS;
    return int'(cfg_taps);
  endfunction

  function automatic longint clamp_acc(input longint v, inout bit clip);
    if (v > ACC_HI) begin
      clip = 1'b1;
      return ACC_HI;
    end
    if (v < ACC_LO) begin
      clip = 1'b1;
      return ACC_LO;
    end
    return v;
  endfunction

  // Applies one word to the shadow; returns 1, with the output, only when the word produces one.
  function automatic bit convolve_word(input fir_word_t w, output fir_result_t r);
    int     taps;
    int     k;
    mode_t  m;
    longint sr;
    longint si;
    bit     clip;
    r = '{default: '0};
    taps = effective_len();
    m = (cfg_mode == MODE_RSVD) ? MODE_REAL : cfg_mode;
    if (w.req == REQ_TAP) begin
      coef_re[w.tidx] = w.tre;
      coef_im[w.tidx] = w.tim;
      return 1'b0;
    end
    if (w.bstart) fill = 0;
    if (fill >= DEF_MAX_BLOCK) return 1'b0;
    for (k = DEF_MAX_TAPS - 1; k > 0; k--) begin
      line_re[k] = line_re[k-1];
      line_im[k] = line_im[k-1];
    end
    line_re[0] = w.sre;
    line_im[0] = w.sim;
    fill++;
    if (fill < taps) return 1'b0;
    sr = 0;
    si = 0;
    clip = 1'b0;
    for (k = 0; k < taps; k++) begin
      sr += longint'(line_re[k]) * longint'(coef_re[k]);
      if (m == MODE_CPLX_SAMPLE)
        si += longint'(line_im[k]) * longint'(coef_re[k]);
      else if (m == MODE_CPLX_TAP)
        si += longint'(line_re[k]) * longint'(coef_im[k]);
    end
    sr = clamp_acc(sr + longint'(w.are), clip);
    if (m != MODE_REAL)
      si = clamp_acc(si + longint'(w.aim), clip);
    else
      si = 0;
    r.re  = q30_t'(sr);
    r.im  = q30_t'(si);
    r.idx = OUT_IDX_BITS'(fill - taps + (taps - 1) / 2);
    r.sat = clip;
    return 1'b1;
  endfunction

  function automatic fir_word_t make_word(input logic req, input logic bstart,
                                          input logic [TAP_IDX_BITS-1:0] tidx,
                                          input q15_t tre, input q15_t tim,
                                          input q15_t sre, input q15_t sim,
                                          input q30_t are, input q30_t aim);
    fir_word_t w;
    w.req = req;
    w.bstart = bstart;
    w.tidx = tidx;
    w.tre = tre;
    w.tim = tim;
    w.sre = sre;
    w.sim = sim;
    w.are = are;
    w.aim = aim;
    return w;
  endfunction

  function automatic q15_t rand16();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return q15_t'($urandom);
    endcase
  endfunction

  function automatic q30_t rand_acc();
    case ($urandom_range(0, 7))
      0: return ACC_MAX;
      1: return ACC_MIN;
      2: return ACC_MAX - q30_t'($urandom);
      3: return ACC_MIN + q30_t'($urandom);
      4: return q30_t'($signed($urandom));
      default: return q30_t'({$urandom, $urandom});
    endcase
  endfunction

  function automatic fir_word_t random_word(input logic req, input logic bstart);
    return make_word(req, bstart, TAP_IDX_BITS'($urandom), rand16(), rand16(),
                     rand16(), rand16(), rand_acc(), rand_acc());
  endfunction

  function automatic stim_row_t word_row(input fir_word_t w);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.w = w;
    r.want = '{default: '0};
    r.reg_idx = '0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input fir_word_t w, input q30_t re,
                                          input logic [OUT_IDX_BITS-1:0] idx,
                                          input logic sat);
    stim_row_t r;
    r = word_row(w);
    r.kind = ROW_TYPED;
    r.want.re = re;
    r.want.idx = idx;
    r.want.sat = sat;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] val);
    stim_row_t r;
    r = word_row(make_word(REQ_TAP, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic send_word(input fir_word_t w);
    fir_result_t r;
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= w.req;
    in_if.block_start <= w.bstart;
    in_if.tap_index   <= w.tidx;
    in_if.tap_re      <= w.tre;
    in_if.tap_im      <= w.tim;
    in_if.sample_re   <= w.sre;
    in_if.sample_im   <= w.sim;
    in_if.acc_re      <= w.are;
    in_if.acc_im      <= w.aim;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (w.req == REQ_TAP) tap_written[w.tidx] = 1'b1;
    if (convolve_word(w, r)) results_due.push_back(r);
  endtask

  // Stop sending and wait for every output; optionally let the chain go quiet.
  task automatic wait_results_done(input bit hold_off);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    if (hold_off) repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_TAP_COUNT)
      cfg_taps = val[TAP_COUNT_BITS-1:0];
    else
      cfg_mode = val[MODE_BITS-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // taps read by the current length must hold a written value
  task automatic load_taps();
    fir_word_t w;
    for (int i = 0; i < effective_len(); i++) begin
      if (!tap_written[i]) begin
        w = random_word(REQ_TAP, 1'b0);
        w.tidx = TAP_IDX_BITS'(i);
        send_word(w);
      end
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("output word with none expected: out_re %0d out_index %0d",
               out_if.out_re, out_if.out_index);
        fail_count++;
      end else begin
        head = results_due.pop_front();
        if (out_if.out_re !== head.re) begin
          $error("out_re: expected %0d, got %0d", head.re, out_if.out_re);
          fail_count++;
        end
        if (out_if.out_im !== head.im) begin
          $error("out_im: expected %0d, got %0d", head.im, out_if.out_im);
          fail_count++;
        end
        if (out_if.out_index !== head.idx) begin
          $error("out_index: expected %0d, got %0d", head.idx, out_if.out_index);
          fail_count++;
        end
        if (out_if.saturated !== head.sat) begin
          $error("saturated: expected %0d, got %0d", head.sat, out_if.saturated);
          fail_count++;
        end
      end
    end
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_fir_valid_convolution_mac: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    int        sent;
    int        n;
    logic [CFG_DATA_BITS-1:0] len_val;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.req_type    <= REQ_TAP;
    in_if.block_start <= 1'b0;
    in_if.tap_index   <= '0;
    in_if.tap_re      <= '0;
    in_if.tap_im      <= '0;
    in_if.sample_re   <= '0;
    in_if.sample_im   <= '0;
    in_if.acc_re      <= '0;
    in_if.acc_im      <= '0;
    fill = 0;
    cfg_taps = TAP_COUNT_BITS'(1);
    cfg_mode = MODE_REAL;
    foreach (tap_written[i]) tap_written[i] = 1'b0;

    // one tap, real mode after reset; block_start on a tap write must not reset the count
    rows.push_back(word_row(make_word(REQ_TAP, 1'b1, 6'd0, 16'sh7FFF, 16'sh8000,
                                      '0, '0, '0, '0)));
    rows.push_back(typed_row(make_word(REQ_SAMPLE, 1'b1, 6'd0, '0, '0, 16'sh7FFF, '0,
                                       '0, '0), 40'sh003FFF0001, 12'd0, 1'b0));
    rows.push_back(typed_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh8000, '0,
                                       '0, '0), -40'sd1073709056, 12'd1, 1'b0));
    rows.push_back(typed_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, '0, '0,
                                       ACC_MAX, '0), ACC_MAX, 12'd2, 1'b0));
    rows.push_back(word_row(make_word(REQ_TAP, 1'b1, 6'd0, 16'sh8000, 16'sh7FFF,
                                      '0, '0, '0, '0)));
    rows.push_back(typed_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh8000, '0,
                                       ACC_MAX, '0), ACC_MAX, 12'd3, 1'b1));
    rows.push_back(typed_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh7FFF, '0,
                                       ACC_MIN, '0), ACC_MIN, 12'd4, 1'b1));
    rows.push_back(cfg_row(REG_DATA_MODE, CFG_DATA_BITS'(MODE_CPLX_SAMPLE)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b1, 6'd0, '0, '0, 16'sh7FFF, 16'sh8000,
                                      '0, ACC_MIN)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh8000, 16'sh7FFF,
                                      ACC_MAX, ACC_MAX)));
    rows.push_back(cfg_row(REG_DATA_MODE, CFG_DATA_BITS'(MODE_CPLX_TAP)));
    rows.push_back(word_row(make_word(REQ_TAP, 1'b0, 6'd0, 16'sh4000, 16'sh8000,
                                      '0, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b1, 6'd0, '0, '0, 16'sh8000, 16'sd12345,
                                      ACC_MIN, ACC_MAX)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh7FFF, -16'sd1,
                                      40'sh123456789A, -40'sd5)));
    // reserved mode falls back to real: imaginary output stays zero
    rows.push_back(cfg_row(REG_DATA_MODE, CFG_DATA_BITS'(MODE_RSVD)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sd1000, -16'sd1000,
                                      40'sd1, ACC_MAX)));
    // zero length acts as one tap
    rows.push_back(cfg_row(REG_TAP_COUNT, 7'd0));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, -16'sd1, 16'sd5,
                                      -40'sd1, 40'sd7)));
    rows.push_back(cfg_row(REG_TAP_COUNT, 7'd4));
    rows.push_back(cfg_row(REG_DATA_MODE, CFG_DATA_BITS'(MODE_REAL)));
    rows.push_back(word_row(make_word(REQ_TAP, 1'b0, 6'd1, 16'sd3, -16'sd7, '0, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_TAP, 1'b0, 6'd2, -16'sd200, 16'sd9, '0, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_TAP, 1'b0, 6'd3, 16'sh7FFF, '0, '0, '0, '0, '0)));
    // fill phase: three words with no output, then outputs start
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b1, 6'd0, '0, '0, 16'sd11, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, -16'sd22, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh8000, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sh7FFF, '0,
                                      40'sd100, '0)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sd5, '0,
                                      -40'sd100, '0)));
    rows.push_back(word_row(make_word(REQ_TAP, 1'b0, 6'd2, 16'sh8000, '0, '0, '0, '0, '0)));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, 16'sd77, '0, '0, '0)));
    // shorter length mid-block applies at once
    rows.push_back(cfg_row(REG_TAP_COUNT, 7'd2));
    rows.push_back(word_row(make_word(REQ_SAMPLE, 1'b0, 6'd0, '0, '0, -16'sd3, '0, '0, '0)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    in_gap_pct = 20;
    out_stall_pct = 20;
    foreach (rows[j]) begin
      if (rows[j].kind == ROW_CFG) begin
        wait_results_done(1'b1);
        write_reg(rows[j].reg_idx, rows[j].reg_val);
      end else begin
        send_word(rows[j].w);
        if (rows[j].kind == ROW_TYPED)
          results_due[results_due.size() - 1] = rows[j].want;
      end
    end

    // random phases: new length and mode each, mostly samples with long blocks
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_results_done(1'b1);
      case ($urandom_range(0, 9))
        0: len_val = 7'd0;
        1: len_val = 7'd127;
        2: len_val = 7'd64;
        3: len_val = CFG_DATA_BITS'($urandom_range(9, 63));
        default: len_val = CFG_DATA_BITS'($urandom_range(1, 8));
      endcase
      write_reg(REG_TAP_COUNT, len_val);
      write_reg(REG_DATA_MODE, CFG_DATA_BITS'($urandom_range(0, 3)));
      in_gap_pct = 15 * $urandom_range(0, 3);
      out_stall_pct = 15 * $urandom_range(0, 3);
      load_taps();
      n = $urandom_range(30, 90);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 59) == 0) wait_results_done(1'b0);
        if ($urandom_range(0, 6) == 0)
          send_word(random_word(REQ_TAP, 1'($urandom)));
        else if (i == 0)
          send_word(random_word(REQ_SAMPLE, 1'($urandom)));
        else
          send_word(random_word(REQ_SAMPLE, $urandom_range(0, 29) == 0));
        sent++;
      end
    end

    // over-range length block, no idling from here on
    wait_results_done(1'b1);
    in_gap_pct = 0;
    out_stall_pct = 0;
    write_reg(REG_TAP_COUNT, 7'd127);
    write_reg(REG_DATA_MODE, CFG_DATA_BITS'($urandom_range(0, 3)));
    load_taps();
    for (int i = 0; i < 80; i++)
      send_word(random_word(REQ_SAMPLE, i == 0));

    wait_results_done(1'b1);
    if (fail_count == 0)
      $display("tb_fir_valid_convolution_mac: clean");
    else
      $display("tb_fir_valid_convolution_mac: errors");
    $finish;
  end

endmodule
